@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the priority queue RTL.
// Both macros expect clk_i in the scope of the caller; SBPQ_ASSERT also expects rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check on every rising edge outside reset.
`define SBPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check on every rising edge, reset included.
`define SBPQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define SBPQ_ASSERT(lbl, prop, msg)
`define SBPQ_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

@@ hw/rtl/sbpq_pkg.sv @@
`default_nettype none

package sbpq_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned HANDLE_BITS = 16;
  localparam int unsigned PRIO_BITS   = 3;

  localparam int unsigned CAP_W     = 5;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [PRIO_BITS-1:0]   prio_t;

  typedef struct packed {
    logic    vld;
    handle_t handle;
    prio_t   prio;
  } entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic    enq;
    logic    deq;
    handle_t handle;
    prio_t   prio;
  } ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/sbpq_if.sv @@
`default_nettype none

interface sbpq_req_if;
  logic                           valid;
  logic                           ready;
  logic                           req_type;
  logic [sbpq_pkg::HANDLE_BITS-1:0] task_handle;
  logic [sbpq_pkg::PRIO_BITS-1:0]   priority_req;

  modport source (output valid, output req_type, output task_handle,
                  output priority_req, input ready);
  modport sink   (input valid, input req_type, input task_handle,
                  input priority_req, output ready);
endinterface

interface sbpq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [sbpq_pkg::STATUS_W-1:0]    status;
  logic [sbpq_pkg::HANDLE_BITS-1:0] out_handle;
  logic [sbpq_pkg::PRIO_BITS-1:0]   out_priority;
  logic [sbpq_pkg::HANDLE_BITS-1:0] head_handle;
  logic [sbpq_pkg::PRIO_BITS-1:0]   head_priority;
  logic [sbpq_pkg::CNT_OUT_W-1:0]   entry_count;
  logic                             is_empty;
  logic                             is_full;

  modport source (output valid, output status, output out_handle,
                  output out_priority, output head_handle, output head_priority,
                  output entry_count, output is_empty, output is_full,
                  input ready);
  modport sink   (input valid, input status, input out_handle,
                  input out_priority, input head_handle, input head_priority,
                  input entry_count, input is_empty, input is_full,
                  output ready);
endinterface

interface sbpq_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [sbpq_pkg::CAP_W-1:0]   capacity;

  modport source (output valid, output capacity, input ready);
  modport sink   (input valid, input capacity, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/sbpq_cell.sv @@
`default_nettype none

module sbpq_cell (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbpq_pkg::ctl_t   ctl_i,
  input  sbpq_pkg::entry_t left_i,
  input  logic             left_keep_i,
  input  sbpq_pkg::entry_t right_i,
  output sbpq_pkg::entry_t ent_o,
  output logic             keep_o
);
  import sbpq_pkg::*;

  logic    vld_q, vld_d;
  handle_t handle_q, handle_d;
  prio_t   prio_q, prio_d;

  // Stay in place when this entry ranks ahead of or equal to the new one.
  assign keep_o = vld_q && (prio_q >= ctl_i.prio);

  always_comb begin
    vld_d    = vld_q;
    handle_d = handle_q;
    prio_d   = prio_q;
    if (ctl_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          vld_d    = 1'b1;
          handle_d = ctl_i.handle;
          prio_d   = ctl_i.prio;
        end else begin
          vld_d    = left_i.vld;
          handle_d = left_i.handle;
          prio_d   = left_i.prio;
        end
      end
    end else if (ctl_i.deq) begin
      vld_d    = right_i.vld;
      handle_d = right_i.handle;
      prio_d   = right_i.prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    handle_q <= handle_d;
    prio_q   <= prio_d;
  end

  assign ent_o = '{vld: vld_q, handle: handle_q, prio: prio_q};

endmodule

`default_nettype wire

@@ hw/rtl/stable_bounded_priority_queue.sv @@
// Stable bounded priority queue of task handles.
// Channels: req_i takes one item per handshake (enqueue or dequeue), rsp_o
// returns exactly one result item for every request, cfg_i writes the
// capacity register (always ready; write only while the queue is idle).
// Entries live in a chain of DEPTH cells sorted highest priority first; an
// enqueue inserts behind all entries of equal or higher priority, a dequeue
// shifts the chain one cell toward the head. Every cell decides locally, so
// an item's result is registered and shows on rsp_o the cycle after
// acceptance, and a new item is taken every cycle as long as the result
// register is empty or being drained.
// When the receiver stalls, the result is held in the output register and
// req_i.ready drops until it is taken.
// Reset empties the queue (count 0, all cells invalid) and sets the capacity
// to 16; no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module stable_bounded_priority_queue (
  input  logic       clk_i,
  input  logic       rst_ni,
  sbpq_req_if.sink   req_i,
  sbpq_rsp_if.source rsp_o,
  sbpq_cfg_if.sink   cfg_i
);
  import sbpq_pkg::*;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    handle_t              out_handle;
    prio_t                out_priority;
    handle_t              head_handle;
    prio_t                head_priority;
    logic [CNT_OUT_W-1:0] entry_count;
    logic                 is_empty;
    logic                 is_full;
  } rsp_t;

  logic [CAP_W-1:0] cap_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             rsp_vld_q;
  rsp_t             rsp_q, rsp_d;

  logic             req_acc;
  logic [CMP_W-1:0] eff_cap;
  logic             full_now;
  logic             not_empty;
  ctl_t             ctl;
  entry_t           head_d;

  entry_t           ent   [DEPTH];
  logic   [DEPTH-1:0] keep;
  logic   [DEPTH-1:0] vld_vec;
  logic   [DEPTH-1:0] therm;
  logic             sorted_ok;

  assign req_i.ready = !rsp_vld_q || rsp_o.ready;
  assign cfg_i.ready = 1'b1;
  assign req_acc     = req_i.valid && req_i.ready;

  // Capacity above the chain length saturates at the chain length.
  assign eff_cap   = (CMP_W'(cap_q) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_q);
  assign full_now  = CMP_W'(count_q) >= eff_cap;
  assign not_empty = count_q != '0;

  assign ctl.enq    = req_acc && (req_i.req_type == REQ_ENQ) && !full_now;
  assign ctl.deq    = req_acc && (req_i.req_type == REQ_DEQ) && not_empty;
  assign ctl.handle = req_i.task_handle;
  assign ctl.prio   = req_i.priority_req;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    logic   left_keep;

    if (g == 0) begin : g_first
      assign left_ent  = '0;
      assign left_keep = 1'b1;
    end else begin : g_mid
      assign left_ent  = ent[g-1];
      assign left_keep = keep[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_inner
      assign right_ent = ent[g+1];
    end

    sbpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctl_i       (ctl),
      .left_i      (left_ent),
      .left_keep_i (left_keep),
      .right_i     (right_ent),
      .ent_o       (ent[g]),
      .keep_o      (keep[g])
    );

    assign vld_vec[g] = ent[g].vld;
  end

  // Head after this step, taken from the current head cells.
  always_comb begin
    head_d = ent[0];
    if (ctl.enq && !keep[0]) begin
      head_d = '{vld: 1'b1, handle: ctl.handle, prio: ctl.prio};
    end else if (ctl.deq) begin
      head_d = ent[1];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctl.enq) begin
      count_d = count_q + CNT_W'(1);
    end else if (ctl.deq) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    rsp_d               = '0;
    rsp_d.status        = ST_DONE;
    if (req_i.req_type == REQ_ENQ) begin
      if (full_now) begin
        rsp_d.status = ST_FULL;
      end
    end else begin
      if (!not_empty) begin
        rsp_d.status = ST_EMPTY;
      end else begin
        rsp_d.out_handle   = ent[0].handle;
        rsp_d.out_priority = ent[0].prio;
      end
    end
    if (head_d.vld) begin
      rsp_d.head_handle   = head_d.handle;
      rsp_d.head_priority = head_d.prio;
    end
    rsp_d.entry_count = CNT_OUT_W'(count_d);
    rsp_d.is_empty    = count_d == '0;
    rsp_d.is_full     = CMP_W'(count_d) >= eff_cap;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q     <= CAP_RESET;
      count_q   <= '0;
      rsp_vld_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        cap_q <= cfg_i.capacity;
      end
      count_q <= count_d;
      if (req_acc) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.status        = rsp_q.status;
  assign rsp_o.out_handle    = rsp_q.out_handle;
  assign rsp_o.out_priority  = rsp_q.out_priority;
  assign rsp_o.head_handle   = rsp_q.head_handle;
  assign rsp_o.head_priority = rsp_q.head_priority;
  assign rsp_o.entry_count   = rsp_q.entry_count;
  assign rsp_o.is_empty      = rsp_q.is_empty;
  assign rsp_o.is_full       = rsp_q.is_full;

  // Cell valid bits must form a run from the head as long as the count.
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      therm[i] = CNT_W'(i) < count_q;
    end
  end

  always_comb begin
    sorted_ok = 1'b1;
    for (int i = 0; i < DEPTH - 1; i++) begin
      if (ent[i+1].vld && (ent[i].prio < ent[i+1].prio)) begin
        sorted_ok = 1'b0;
      end
    end
  end

  `SBPQ_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH), "count above depth")
  `SBPQ_ASSERT(a_vld_thermo, vld_vec == therm, "cell valid bits disagree with count")
  `SBPQ_ASSERT(a_sorted, sorted_ok, "chain not sorted by priority")
  `SBPQ_ASSERT(a_rsp_follows, req_acc |=> rsp_vld_q, "accepted item gave no result")
  `SBPQ_ASSERT(a_deq_count, ctl.deq |=> count_q == $past(count_q) - CNT_W'(1), "dequeue count")

endmodule

`default_nettype wire

@@ tb/tb_stable_bounded_priority_queue.sv @@
module tb_stable_bounded_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import sbpq_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    handle_t              out_handle;
    prio_t                out_prio;
    handle_t              head_handle;
    prio_t                head_prio;
    logic [CNT_OUT_W-1:0] count;
    logic                 empty;
    logic                 full;
  } queue_result_t;

  // A typed-in result overrides the prediction for its item.
  typedef struct packed {
    logic          typed;
    queue_result_t want;
  } pinned_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    logic [CAP_W-1:0] cap;
    logic             req;
    handle_t          handle;
    prio_t            prio;
    logic             typed;
    queue_result_t    want;
  } row_t;

  localparam queue_result_t NO_CHECK = '0;
  localparam int unsigned SCRIPT_ROWS = 29;

  localparam row_t SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'hFFFF, 3'd7, 1'b1,
      '{ST_EMPTY, 16'h0, 3'd0, 16'h0, 3'd0, 5'd0, 1'b1, 1'b0}},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0000, 3'd0, 1'b1,
      '{ST_DONE, 16'h0, 3'd0, 16'h0, 3'd0, 5'd1, 1'b0, 1'b0}},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'hFFFF, 3'd7, 1'b1,
      '{ST_DONE, 16'h0, 3'd0, 16'hFFFF, 3'd7, 5'd2, 1'b0, 1'b0}},
    // equal priorities must leave in arrival order
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h1111, 3'd3, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h2222, 3'd3, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h3333, 3'd7, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'hAAAA, 3'd5, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h5555, 3'd0, 1'b0, NO_CHECK},
    // dequeue fields carry noise that must be ignored
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h1234, 3'd2, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'hFFFF, 3'd7, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h0000, 3'd0, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'hA5A5, 3'd5, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h5A5A, 3'd2, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h8001, 3'd4, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h7FFE, 3'd1, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h0F0F, 3'd6, 1'b1,
      '{ST_EMPTY, 16'h0, 3'd0, 16'h0, 3'd0, 5'd0, 1'b1, 1'b0}},
    // zero capacity: full even while empty
    '{ROW_CFG,  5'd0, REQ_ENQ, 16'h0000, 3'd0, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'hBEEF, 3'd4, 1'b1,
      '{ST_FULL, 16'h0, 3'd0, 16'h0, 3'd0, 5'd0, 1'b1, 1'b1}},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h0000, 3'd0, 1'b1,
      '{ST_EMPTY, 16'h0, 3'd0, 16'h0, 3'd0, 5'd0, 1'b1, 1'b1}},
    '{ROW_CFG,  5'd31, REQ_ENQ, 16'h0000, 3'd0, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0101, 3'd1, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0202, 3'd2, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0303, 3'd2, 1'b0, NO_CHECK},
    // capacity drops below the held count
    '{ROW_CFG,  5'd1, REQ_ENQ, 16'h0000, 3'd0, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0404, 3'd6, 1'b1,
      '{ST_FULL, 16'h0, 3'd0, 16'h0202, 3'd2, 5'd3, 1'b0, 1'b1}},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'hFFFF, 3'd7, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h0000, 3'd0, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_DEQ, 16'h1234, 3'd3, 1'b0, NO_CHECK},
    '{ROW_ITEM, 5'd0, REQ_ENQ, 16'h0505, 3'd7, 1'b0, NO_CHECK}
  };

  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 50;

  logic clk = 1'b0;
  logic rst_n;

  sbpq_req_if req_if ();
  sbpq_rsp_if rsp_if ();
  sbpq_cfg_if cfg_if ();

  stable_bounded_priority_queue u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the queue
  handle_t          ent_handle [DEPTH];
  prio_t            ent_prio [DEPTH];
  int unsigned      fill_level = 0;
  logic [CAP_W-1:0] cap_setting = CAP_RESET;

  queue_result_t pending_results [$];
  pinned_t       pinned_q [$];
  int unsigned   sent_cnt = 0;
  int unsigned   rsp_cnt = 0;
  int unsigned   err_cnt = 0;
  int unsigned   cycles = 0;
  bit            src_idle = 1'b1;
  bit            sink_idle = 1'b1;

  function automatic queue_result_t predict_queue_result(logic req, handle_t h, prio_t p);
    queue_result_t r;
    int unsigned   eff_cap;
    int unsigned   pos;
    int unsigned   i;
    r = '0;
    r.status = ST_DONE;
    eff_cap = (cap_setting > DEPTH) ? DEPTH : cap_setting;
    if (req == REQ_ENQ) begin
      if (fill_level >= eff_cap || fill_level >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < fill_level && ent_prio[pos] >= p) pos++;
        for (i = fill_level; i > pos; i--) begin
          ent_handle[i] = ent_handle[i-1];
          ent_prio[i]   = ent_prio[i-1];
        end
        ent_handle[pos] = h;
        ent_prio[pos]   = p;
        fill_level++;
      end
    end else begin
      if (fill_level == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.out_handle = ent_handle[0];
        r.out_prio   = ent_prio[0];
        for (i = 1; i < fill_level; i++) begin
          ent_handle[i-1] = ent_handle[i];
          ent_prio[i-1]   = ent_prio[i];
        end
        fill_level--;
      end
    end
    r.head_handle = (fill_level != 0) ? ent_handle[0] : '0;
    r.head_prio   = (fill_level != 0) ? ent_prio[0] : '0;
    r.count       = fill_level[CNT_OUT_W-1:0];
    r.empty       = (fill_level == 0);
    r.full        = (fill_level >= eff_cap);
    return r;
  endfunction

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endtask

  // Observe all three channels at the clock edge
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    queue_result_t pred;
    pinned_t       pin;
    if (rst_n) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got = '{rsp_if.status, rsp_if.out_handle, rsp_if.out_priority,
                rsp_if.head_handle, rsp_if.head_priority, rsp_if.entry_count,
                rsp_if.is_empty, rsp_if.is_full};
        if (pending_results.size() == 0) begin
          $error("result item with nothing expected");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 16'(want.status), 16'(got.status));
          check_field("out_handle", want.out_handle, got.out_handle);
          check_field("out_priority", 16'(want.out_prio), 16'(got.out_prio));
          check_field("head_handle", want.head_handle, got.head_handle);
          check_field("head_priority", 16'(want.head_prio), 16'(got.head_prio));
          check_field("entry_count", 16'(want.count), 16'(got.count));
          check_field("is_empty", 16'(want.empty), 16'(got.empty));
          check_field("is_full", 16'(want.full), 16'(got.full));
        end
        rsp_cnt++;
      end
      if (cfg_if.valid && cfg_if.ready) cap_setting = cfg_if.capacity;
      if (req_if.valid && req_if.ready) begin
        pin  = pinned_q.pop_front();
        pred = predict_queue_result(req_if.req_type, req_if.task_handle,
                                    req_if.priority_req);
        pending_results.push_back(pin.typed ? pin.want : pred);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result receiver with random stalls
  initial begin
    int unsigned stall;
    rsp_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = sink_idle ? $urandom_range(0, 9) : 0;
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
    end
  end

  task automatic send_request(logic req, handle_t h, prio_t p, pinned_t pin);
    int unsigned gap;
    gap = src_idle ? $urandom_range(0, 9) : 0;
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pinned_q.push_back(pin);
    req_if.valid        <= 1'b1;
    req_if.req_type     <= req;
    req_if.task_handle  <= h;
    req_if.priority_req <= p;
    do @(posedge clk); while (!req_if.ready);
    sent_cnt++;
  endtask

  // Hold requests until every outstanding result has come back
  task automatic settle();
    req_if.valid <= 1'b0;
    while (rsp_cnt != sent_cnt) @(posedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    cfg_if.valid    <= 1'b1;
    cfg_if.capacity <= cap;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] phase_cap [PHASES];
    int unsigned      enq_pct;
    logic             req;
    handle_t          h;
    prio_t            p;
    rst_n               = 1'b0;
    req_if.valid        = 1'b0;
    req_if.req_type     = REQ_ENQ;
    req_if.task_handle  = '0;
    req_if.priority_req = '0;
    cfg_if.valid        = 1'b0;
    cfg_if.capacity     = CAP_RESET;
    phase_cap = '{5'd16, 5'd31, 5'd3, 5'd0, 5'd16, 5'd1, 5'd20, 5'd16};
    phase_cap[PHASES-1] = 5'($urandom_range(0, 31));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < SCRIPT_ROWS; r++) begin
      if (SCRIPT[r].kind == ROW_CFG) begin
        settle();
        write_capacity(SCRIPT[r].cap);
      end else begin
        send_request(SCRIPT[r].req, SCRIPT[r].handle, SCRIPT[r].prio,
                     '{SCRIPT[r].typed, SCRIPT[r].want});
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      write_capacity(phase_cap[ph]);
      src_idle  = (ph % 4) != 1;
      sink_idle = (ph % 4) != 2;
      // alternate filling, draining and balanced traffic
      enq_pct = (ph % 3 == 0) ? 80 : ((ph % 3 == 1) ? 25 : 50);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        req = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQ : REQ_DEQ;
        case ($urandom_range(0, 7))
          0: h = '0;
          1: h = '1;
          default: h = handle_t'($urandom);
        endcase
        // narrow priority range now and then to pile up ties
        p = $urandom_range(0, 1) ? prio_t'($urandom_range(0, 7))
                                 : prio_t'($urandom_range(6, 7));
        send_request(req, h, p, '{1'b0, NO_CHECK});
      end
    end

    settle();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d expected result items never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/sbpq_pkg.sv
hw/rtl/sbpq_if.sv
hw/rtl/sbpq_cell.sv
hw/rtl/stable_bounded_priority_queue.sv
tb/tb_stable_bounded_priority_queue.sv
